FILE: hdl/twi_pkg.sv
// twi_pkg: shared constants, the transfer-curve ROM and its read function
// for the table waveshaper. No dependencies.
`timescale 1ns / 1ps

package twi_pkg;

    localparam int TABLE_ENTRIES_DEF = 100;
    localparam int TABLE_ENTRIES_MAX = 1024;
    localparam int SAMPLE_W          = 16;
    localparam int FRAC_W            = 16;

    // Curve ROM: signed, 16 fraction bits
    localparam int ROM_SIZE   = 100;
    localparam int ROM_IDX_W  = 7;
    localparam int ROM_ADDR_W = 10;
    localparam int CURVE_W    = 26;
    localparam int DIFF_W     = CURVE_W + 1;
    localparam int PROD_W     = FRAC_W + 1 + DIFF_W;
    localparam int ACC_W      = PROD_W + 1;

    // Output scaling: divide by 300 * 2^17, round half up
    localparam int                 DOWN_SHIFT = 17;
    localparam logic [ACC_W-1:0]   ROUND_HALF = ACC_W'(19660800);
    localparam int                 MM_W       = 25;
    localparam logic [MM_W-1:0]    DIV_BIAS   = MM_W'(9830400);  // 300 * 2^15
    localparam logic [23:0]        RECIP      = 24'd14316557;    // floor(2^32 / 300)
    localparam int                 RECIP_SH   = 32;
    localparam int                 Q0_W       = 17;
    localparam logic [8:0]         DIV_DEN    = 9'd300;
    localparam int                 BIAS_Q     = 32768;

    typedef logic signed [CURVE_W-1:0] t_curve;

    localparam t_curve CURVE_ROM [ROM_SIZE] = '{
        26'sd17096638, 26'sd17063055, 26'sd17018455, 26'sd16962846, 26'sd16916397,
        26'sd16864045, 26'sd16797141, 26'sd16731472, 26'sd16668559, 26'sd16585928,
        26'sd16491747, 26'sd16425005, 26'sd16342238, 26'sd16243445, 26'sd16110070,
        26'sd15935964, 26'sd15720928, 26'sd15555198, 26'sd15440248, 26'sd15319069,
        26'sd15192279, 26'sd15115470, 26'sd15048743, 26'sd14980879, 26'sd14911898,
        26'sd14841854, 26'sd14770772, 26'sd14698648, 26'sd14567028, 26'sd14415348,
        26'sd14257882, 26'sd14173950, 26'sd14089757, 26'sd14002583, 26'sd13912061,
        26'sd13818214, 26'sd13721603, 26'sd13623029, 26'sd13523192, 26'sd13422533,
        26'sd13321305, 26'sd13201259, 26'sd12934235, 26'sd12668757, 26'sd12401356,
        26'sd12132030, 26'sd11860952, 26'sd11588325, 26'sd11314166, 26'sd11090223,
        26'sd10890638, 26'sd10690452, 26'sd10441611, 26'sd10216083, 26'sd9998873,
        26'sd9781415,  26'sd9563914,  26'sd9346604,  26'sd9129812,  26'sd9002276,
        26'sd8894551,  26'sd8787202,  26'sd8680332,  26'sd8574027,  26'sd8468385,
        26'sd8337414,  26'sd8131150,  26'sd7929886,  26'sd7734932,  26'sd7547787,
        26'sd7369803,  26'sd7189950,  26'sd6959868,  26'sd6782401,  26'sd6691868,
        26'sd6606839,  26'sd6527313,  26'sd6428075,  26'sd6381040,  26'sd6336822,
        26'sd6295485,  26'sd6257074,  26'sd6221595,  26'sd6176185,  26'sd6120997,
        26'sd6056887,  26'sd6017628,  26'sd5984080,  26'sd5956243,  26'sd5876477,
        26'sd5804080,  26'sd5756941,  26'sd5721339,  26'sd5684220,  26'sd5654663,
        26'sd5631729,  26'sd5610648,  26'sd5592155,  26'sd5576249,  26'sd5574573
    };

    // Addresses past the ROM read the last entry
    function automatic t_curve curve_read(input logic [ROM_ADDR_W-1:0] addr);
        logic [ROM_IDX_W-1:0] a;
        a = (addr >= ROM_ADDR_W'(ROM_SIZE)) ? ROM_IDX_W'(ROM_SIZE - 1)
                                             : addr[ROM_IDX_W-1:0];
        return CURVE_ROM[a];
    endfunction

endpackage

FILE: hdl/twi_addr.sv
// twi_addr: stage 1, maps the sample to a curve position (entry index and
// 16-bit weight). Depends on twi_pkg.
`timescale 1ns / 1ps

module twi_addr
    import twi_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_valid,
    output logic        [IDX_W-1:0]    o_idx,
    output logic        [FRAC_W-1:0]   o_frac
);

    localparam int                POS_W = FRAC_W + IDX_W;
    localparam logic [IDX_W-1:0]  SPAN  = IDX_W'(TABLE_ENTRIES - 1);

    logic [SAMPLE_W-1:0] u;
    logic [POS_W-1:0]    pos;
    logic                r_valid;
    logic [IDX_W-1:0]    r_idx;
    logic [FRAC_W-1:0]   r_frac;

    // offset binary: x + 1.0
    assign u   = {~i_sample[SAMPLE_W-1], i_sample[SAMPLE_W-2:0]};
    assign pos = POS_W'(u) * POS_W'(SPAN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= pos[POS_W-1:FRAC_W];
        r_frac <= pos[FRAC_W-1:0];
    end

    assign o_valid = r_valid;
    assign o_idx   = r_idx;
    assign o_frac  = r_frac;

endmodule

FILE: hdl/twi_interp.sv
// twi_interp: stages 2 and 3, ROM read of both neighbours, then the
// weighted difference product. Depends on twi_pkg.
`timescale 1ns / 1ps

module twi_interp
    import twi_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic        [IDX_W-1:0]  i_idx,
    input  logic        [FRAC_W-1:0] i_frac,
    output logic                     o_valid,
    output logic signed [DIFF_W-1:0] o_base,
    output logic signed [PROD_W-1:0] o_prod
);

    localparam logic [ROM_ADDR_W-1:0] MID_ADDR = ROM_ADDR_W'(TABLE_ENTRIES / 2);
    localparam t_curve                MID_VAL  = curve_read(MID_ADDR);

    t_curve                    lo;
    t_curve                    hi;
    logic                      r_valid2;
    logic signed [DIFF_W-1:0]  r_base2;
    logic signed [DIFF_W-1:0]  r_diff2;
    logic        [FRAC_W-1:0]  r_frac2;
    logic signed [FRAC_W:0]    wgt;
    logic                      r_valid3;
    logic signed [DIFF_W-1:0]  r_base3;
    logic signed [PROD_W-1:0]  r_prod3;

    assign lo  = curve_read(ROM_ADDR_W'(i_idx));
    assign hi  = curve_read(ROM_ADDR_W'(i_idx) + ROM_ADDR_W'(1));
    assign wgt = $signed({1'b0, r_frac2});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else begin
            r_valid2 <= i_valid;
            r_valid3 <= r_valid2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base2 <= DIFF_W'(lo) - DIFF_W'(MID_VAL);
        r_diff2 <= DIFF_W'(hi) - DIFF_W'(lo);
        r_frac2 <= i_frac;
        r_base3 <= r_base2;
        r_prod3 <= PROD_W'(wgt) * PROD_W'(r_diff2);
    end

    assign o_valid = r_valid3;
    assign o_base  = r_base3;
    assign o_prod  = r_prod3;

endmodule

FILE: hdl/twi_scale.sv
// twi_scale: stages 4 to 6, sum, rounding shift, divide by 300 through a
// reciprocal with one correction step, and saturation. Depends on twi_pkg.
`timescale 1ns / 1ps

module twi_scale
    import twi_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic signed [DIFF_W-1:0]   i_base,
    input  logic signed [PROD_W-1:0]   i_prod,
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    localparam int               PR_W  = MM_W + 24;
    localparam int               REM_W = MM_W + 1;
    localparam int               Q_W   = Q0_W + 2;
    localparam logic signed [Q_W-1:0] SAT_HI = Q_W'(32767);
    localparam logic signed [Q_W-1:0] SAT_LO = -Q_W'(32768);

    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    shifted;
    logic        [ACC_W-1:0]    biased;
    logic                       r_valid4;
    logic        [MM_W-1:0]     r_mm4;
    logic        [PR_W-1:0]     recip_prod;
    logic                       r_valid5;
    logic        [MM_W-1:0]     r_mm5;
    logic        [Q0_W-1:0]     r_q05;
    logic        [REM_W-1:0]    q0x;
    logic        [REM_W-1:0]    rem;
    logic signed [Q_W-1:0]      q;
    logic signed [SAMPLE_W-1:0] sat;
    logic                       r_valid6;
    logic signed [SAMPLE_W-1:0] r_out6;

    // stage 4: y - mid, + half, floor shift, bias to non-negative
    assign acc     = (ACC_W'(i_base) <<< FRAC_W) + ACC_W'(i_prod) + ROUND_HALF;
    assign shifted = acc >>> DOWN_SHIFT;
    assign biased  = shifted + ACC_W'(DIV_BIAS);

    // stage 5: quotient estimate, low by at most one
    assign recip_prod = PR_W'(r_mm4) * PR_W'(RECIP);

    // stage 6: correct, unbias, clamp
    assign q0x = REM_W'(r_q05) * REM_W'(DIV_DEN);
    assign rem = REM_W'(r_mm5) - q0x;
    assign q   = $signed(Q_W'(r_q05)) + $signed(Q_W'(rem >= REM_W'(DIV_DEN)))
               - Q_W'(BIAS_Q);

    always_comb begin
        if (q > SAT_HI) begin
            sat = SAMPLE_W'(SAT_HI);
        end else if (q < SAT_LO) begin
            sat = SAMPLE_W'(SAT_LO);
        end else begin
            sat = q[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid4 <= 1'b0;
            r_valid5 <= 1'b0;
            r_valid6 <= 1'b0;
        end else begin
            r_valid4 <= i_valid;
            r_valid5 <= r_valid4;
            r_valid6 <= r_valid5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mm4  <= biased[MM_W-1:0];
        r_mm5  <= r_mm4;
        r_q05  <= recip_prod[RECIP_SH +: Q0_W];
        r_out6 <= sat;
    end

    assign o_valid  = r_valid6;
    assign o_sample = r_out6;

endmodule

FILE: hdl/table_waveshaper_interp_core.sv
// table_waveshaper_interp_core: top level of the table waveshaper.
// Depends on twi_pkg, twi_addr, twi_interp and twi_scale.
`timescale 1ns / 1ps

// Memoryless waveshaper over a fixed transfer curve. A transaction is taken
// on any rising edge with start high; busy is tied low, so a new sample may
// be issued every clock cycle with no gaps. Each sample's result appears on
// o_sample_out out of the last register stage, marked by a one-cycle o_valid
// strobe; the receiver cannot stall, and the pipeline never holds, so the
// result must be captured in that cycle. Throughput is one sample per clock,
// since every stage takes a new sample each cycle and nothing is iterated.
// The datapath has six register stages, in order: position multiply, ROM
// read, weight multiply, rounding sum, reciprocal multiply, and correction
// and saturation. Reset only clears the valid chain; there is no state.
module table_waveshaper_interp_core
    import twi_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_sample_out
);

    // Index width for the lower entry; i + 1 always stays below TABLE_ENTRIES
    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic                     s1_valid;
    logic [IDX_W-1:0]         s1_idx;
    logic [FRAC_W-1:0]        s1_frac;
    logic                     s3_valid;
    logic signed [DIFF_W-1:0] s3_base;
    logic signed [PROD_W-1:0] s3_prod;

    // Fully pipelined: never refuses a transaction
    assign busy = 1'b0;

    // Stage 1: position = (x + 1) / 2 * (entries - 1), Q16
    twi_addr #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_addr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start),
        .i_sample (i_sample_in),
        .o_valid  (s1_valid),
        .o_idx    (s1_idx),
        .o_frac   (s1_frac)
    );

    // Stages 2-3: neighbour entries relative to the midpoint entry, and
    // weight * slope; a zero weight gives the lower entry alone
    twi_interp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_idx   (s1_idx),
        .i_frac  (s1_frac),
        .o_valid (s3_valid),
        .o_base  (s3_base),
        .o_prod  (s3_prod)
    );

    // Stages 4-6: /300 to Q1.15, round half up, saturate
    twi_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s3_valid),
        .i_base   (s3_base),
        .i_prod   (s3_prod),
        .o_valid  (o_valid),
        .o_sample (o_sample_out)
    );

endmodule

FILE: sim/tb.sv
// tb: self-checking bench for table_waveshaper_interp_core, the lookup-curve
// waveshaper with linear interpolation. Needs twi_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

    import twi_pkg::SAMPLE_W;

    // ---------------------------------------------------------------------
    // Bench constants
    // ---------------------------------------------------------------------
    localparam int      PIPE_LAT       = 6;     // sample to strobe, through the core's register stages
    localparam int      NUM_ENTRIES    = 100;   // curve points the core is built with
    localparam int      ROM_ENTRIES    = 100;   // points actually stored
    localparam int      N_RANDOM       = 1750;
    localparam int      N_QUIET_TAIL   = 300;   // last random transactions: no gaps
    localparam int      WATCHDOG_LIMIT = 400;
    localparam longint  SCALE_DEN      = 300 * 131072;  // /300, Q32 down to Q1.15

    // Curve points in units of 1e-8; turned into Q16 by curve_q16()
    localparam longint CURVE_SRC [ROM_ENTRIES] = '{
        64'sd26087400000, 64'sd26036155152, 64'sd25968101616, 64'sd25883249394,
        64'sd25812373131, 64'sd25732490505, 64'sd25630403636, 64'sd25530199798,
        64'sd25434203232, 64'sd25308117273, 64'sd25164408485, 64'sd25062568889,
        64'sd24936276061, 64'sd24785529798, 64'sd24582016162, 64'sd24316351212,
        64'sd23988231717, 64'sd23735347980, 64'sd23559948182, 64'sd23375043737,
        64'sd23181578283, 64'sd23064376970, 64'sd22962558889, 64'sd22859006869,
        64'sd22753750909, 64'sd22646871717, 64'sd22538408687, 64'sd22428356364,
        64'sd22227520101, 64'sd21996075758, 64'sd21755801212, 64'sd21627730909,
        64'sd21499263636, 64'sd21366246667, 64'sd21228120808, 64'sd21084921515,
        64'sd20937504545, 64'sd20787093333, 64'sd20634754040, 64'sd20481160303,
        64'sd20326698990, 64'sd20143521919, 64'sd19736075758, 64'sd19330988586,
        64'sd18922967778, 64'sd18512009091, 64'sd18098376869, 64'sd17682380606,
        64'sd17264047273, 64'sd16922337879, 64'sd16617794545, 64'sd16312334848,
        64'sd15932633939, 64'sd15588505556, 64'sd15257070000, 64'sd14925255556,
        64'sd14593375152, 64'sd14261785152, 64'sd13930987273, 64'sd13736382626,
        64'sd13572008182, 64'sd13408206162, 64'sd13245135758, 64'sd13082926364,
        64'sd12921729596, 64'sd12721884545, 64'sd12407150000, 64'sd12100046061,
        64'sd11802568990, 64'sd11517009697, 64'sd11245427374, 64'sd10970993535,
        64'sd10619916364, 64'sd10349122626, 64'sd10210980404, 64'sd10081236667,
        64'sd9959889232,  64'sd9808463889,  64'sd9736694788,  64'sd9669223283,
        64'sd9606147778,  64'sd9547537636,  64'sd9493400081,  64'sd9424110576,
        64'sd9339900939,  64'sd9242075859,  64'sd9182170939,  64'sd9130980818,
        64'sd9088505333,  64'sd8966791747,  64'sd8856323182,  64'sd8784395242,
        64'sd8730069909,  64'sd8673431242,  64'sd8628330707,  64'sd8593335990,
        64'sd8561168818,  64'sd8532950929,  64'sd8508680323,  64'sd8506124000
    };

    // Directed vector: sample, whether the answer is typed in, and that answer
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       known;
        logic signed [SAMPLE_W-1:0] result;
    } shape_vec_t;

    // Expected result waiting for its strobe, with its sample for reporting
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SAMPLE_W-1:0] result;
    } shaped_t;

    // Directed part. Typed answers:
    //   -1.0 sits exactly on the first point (zero weight, lower clip):
    //     (T[0] - T[50]) / 600 in Q16 units -> 6206000 / 600 = 10343.33 -> 10343
    //   0.0 sits half way between points 49 and 50:
    //     (T[49] - T[50]) / 1200 -> 199585 / 1200 = 166.32 -> 166
    // The rest straddle segment knees, the top end and the bit patterns.
    localparam int N_DIRECTED = 23;
    localparam shape_vec_t DIR_VECS [N_DIRECTED] = '{
        '{16'sh8000,    1'b1, 16'sd10343},  // -1.0, exact point, lower clip
        '{16'sd0,       1'b1, 16'sd166},    // midpoint
        '{-16'sd32767,  1'b0, 16'sd0},      // one step above -1.0
        '{16'sd32767,   1'b0, 16'sd0},      // top end, near last point
        '{16'sd32766,   1'b0, 16'sd0},
        '{-16'sd1,      1'b0, 16'sd0},      // all ones
        '{16'sd1,       1'b0, 16'sd0},
        '{16'sd16384,   1'b0, 16'sd0},
        '{-16'sd16384,  1'b0, 16'sd0},
        '{16'sh5555,    1'b0, 16'sd0},      // alternating bits
        '{16'shAAAA,    1'b0, 16'sd0},
        '{16'sd330,     1'b0, 16'sd0},      // last position in segment 49
        '{16'sd331,     1'b0, 16'sd0},      // first position in segment 50
        '{-16'sd32107,  1'b0, 16'sd0},      // end of segment 0
        '{-16'sd32106,  1'b0, 16'sd0},      // start of segment 1, tiny weight
        '{16'sd32106,   1'b0, 16'sd0},      // end of segment 97
        '{16'sd32107,   1'b0, 16'sd0},      // start of the last segment
        '{-16'sd32000,  1'b0, 16'sd0},
        '{16'sd12345,   1'b0, 16'sd0},
        '{-16'sd12345,  1'b0, 16'sd0},
        '{16'sd255,     1'b0, 16'sd0},
        '{-16'sd256,    1'b0, 16'sd0},
        '{16'sh7F00,    1'b0, 16'sd0}
    };

    // ---------------------------------------------------------------------
    // DUT hook-up
    // ---------------------------------------------------------------------
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       start       = 1'b0;
    logic                       busy;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic                       o_valid;
    logic signed [SAMPLE_W-1:0] o_sample_out;

    table_waveshaper_interp_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_sample_in  (i_sample_in),
        .o_valid      (o_valid),
        .o_sample_out (o_sample_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Scoreboard state
    // ---------------------------------------------------------------------
    shaped_t shaped_due [$];
    shaped_t shaped_head;
    int      err_count     = 0;
    int      results_seen  = 0;
    int      n_sent        = 0;
    int      n_knee        = 0;
    int      n_edge        = 0;
    int      stall_cycles  = 0;

    // Curve point in Q16, rounded to nearest; addresses past the store read
    // the last point
    function automatic longint curve_q16(input int unsigned idx);
        if (idx >= ROM_ENTRIES)
            idx = ROM_ENTRIES - 1;
        return (CURVE_SRC[idx] * 64'sd65536 + 64'sd50000000) / 64'sd100000000;
    endfunction

    // Shaped output for one sample: position over the curve, linear blend,
    // minus the midpoint, /300, round half up, saturate
    function automatic logic signed [SAMPLE_W-1:0] shape_sample(
        input logic signed [SAMPLE_W-1:0] x
    );
        logic [15:0]  u;
        logic [31:0]  pos;
        int unsigned  seg;
        longint       frac, lo, acc, n, q;
        u   = x ^ 16'h8000;                 // offset binary, 0 = -1.0
        pos = 32'(u) * 32'(NUM_ENTRIES - 1);
        seg = pos[31:16];
        frac = longint'(pos[15:0]);
        lo  = curve_q16(seg);
        acc = lo * 64'sd65536;
        if (frac != 0)                      // exact point: weight is zero
            acc += frac * (curve_q16(seg + 1) - lo);
        acc -= curve_q16(NUM_ENTRIES / 2) * 64'sd65536;
        n = acc + SCALE_DEN / 2;
        q = n / SCALE_DEN;
        if (n % SCALE_DEN < 0)              // floor, not truncation
            q -= 1;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return SAMPLE_W'(q);
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------

    // Offer one sample and hold it until the core takes it. busy is read
    // just after the edge, so it is the value the core saw at that edge.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic known,
                               input logic signed [SAMPLE_W-1:0] typed);
        shaped_t due;
        start       <= 1'b1;
        i_sample_in <= s;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        due.sample = s;
        due.result = known ? typed : shape_sample(s);
        shaped_due.push_back(due);
        n_sent++;
    endtask

    // Sender gap with start low; the data bus carries junk meanwhile
    task automatic sender_gap();
        start       <= 1'b0;
        i_sample_in <= SAMPLE_W'($urandom);
        repeat ($urandom_range(1, 7)) @(posedge i_clk);
    endtask

    initial begin : stim
        logic signed [SAMPLE_W-1:0] s;
        int                         knee_u;
        int                         off;

        // Reset held, then released once
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_VECS[k]) begin
            if ($urandom_range(0, 3) == 0)
                sender_gap();
            send_sample(DIR_VECS[k].sample, DIR_VECS[k].known, DIR_VECS[k].result);
        end

        // Random part: mostly uniform, some around segment knees (where the
        // integer part steps) and some hugging the two ends of the range
        for (int k = 0; k < N_RANDOM; k++) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    knee_u = (int'($urandom_range(1, NUM_ENTRIES - 2)) * 65536
                              + NUM_ENTRIES - 2) / (NUM_ENTRIES - 1)
                             + int'($urandom_range(0, 4)) - 2;
                    s = SAMPLE_W'(knee_u) ^ 16'h8000;
                    n_knee++;
                end
                2: begin
                    off = $urandom_range(0, 31);
                    s = ($urandom_range(0, 1) == 0) ? 16'sh8000 + SAMPLE_W'(off)
                                                    : 16'sh7FFF - SAMPLE_W'(off);
                    n_edge++;
                end
                default: s = SAMPLE_W'($urandom);
            endcase
            if (k < N_RANDOM - N_QUIET_TAIL && $urandom_range(0, 5) == 0)
                sender_gap();
            send_sample(s, 1'b0, '0);
        end
        start <= 1'b0;

        // Drain, then give any stray strobes a chance to show up
        while (shaped_due.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);

        $display("Shaped %0d samples (%0d directed, %0d near knees, %0d near the ends),",
                 n_sent, N_DIRECTED, n_knee, n_edge);
        $display("checked %0d results against the curve model, %0d mismatches.",
                 results_seen, err_count);
        if (err_count == 0)
            $display("PASS table_waveshaper_interp_core");
        else
            $display("FAIL table_waveshaper_interp_core");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Result checker: every strobe must match the oldest expectation. The
    // receiver cannot stall, so each strobe is one transaction. An X on the
    // strobe after reset counts as a strobe and is flagged.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid !== 1'b0) begin
            if (shaped_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0d (valid %b)",
                         $time, o_sample_out, o_valid);
                err_count++;
            end else begin
                shaped_head = shaped_due.pop_front();
                results_seen++;
                if (o_valid !== 1'b1 || o_sample_out !== shaped_head.result) begin
                    $display("%0t: sample_out mismatch for sample %0d: expected %0d, got %0d",
                             $time, shaped_head.sample, shaped_head.result, o_sample_out);
                    err_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Watchdog: too many cycles in a row with no transaction on either side
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, shaped_due.size());
            $display("FAIL table_waveshaper_interp_core");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

FILE: filelist.f
hdl/twi_pkg.sv
hdl/twi_addr.sv
hdl/twi_interp.sv
hdl/twi_scale.sv
hdl/table_waveshaper_interp_core.sv
sim/tb.sv
